### hdl/smi_pkg.sv
`default_nettype none

package smi_pkg;

  localparam int AXIS_COUNT   = 12;
  localparam int AXIS_IDX_W   = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int AXIS_FIELD_W = 4;

  localparam int ANGLE_W    = 32;
  localparam int TIME_W     = 32;
  localparam int DUR_W      = 16;
  localparam int RPM_W      = 10;
  localparam int MAG_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int SMOOTH_W   = FRAC_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Divider: the duration numerator is largest_delta * 1000, below 2^41.
  // The denominator 1536 * rpm stays below 2^21 for any 10-bit rpm.
  localparam int NUM_W  = 41;
  localparam int DEN_W  = 21;
  localparam int STEP_W = $clog2(NUM_W + 1);

  localparam logic [STEP_W-1:0] STEPS_DURATION = STEP_W'(NUM_W);
  localparam logic [STEP_W-1:0] STEPS_PHASE    = STEP_W'(FRAC_W);

  // Multiplier: signed A times unsigned B.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

  localparam logic [RPM_W-1:0]   RPM_RESET    = 10'd60;
  localparam logic [DUR_W-1:0]   MIN_MS_RESET = 16'd800;
  localparam logic [DUR_W-1:0]   MAX_MS_RESET = 16'd4000;
  localparam logic [MUL_B_W-1:0] MS_PER_S     = 18'd1000;
  localparam logic [MUL_B_W-1:0] SMOOTH_THREE = 18'd196608;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATED_RPM   = 2'd0,
    CFG_MIN_MOVE_MS = 2'd1,
    CFG_MAX_MOVE_MS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  numer;
    logic [DEN_W-1:0]  rem_init;
    logic [DEN_W-1:0]  denom;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### hdl/smi_in_if.sv
`default_nettype none

interface smi_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   opcode;
  logic [smi_pkg::AXIS_FIELD_W-1:0]       axis_sel;
  logic signed [smi_pkg::ANGLE_W-1:0]     delta_deg;
  logic                                   last_axis;
  logic [smi_pkg::TIME_W-1:0]             now_ms;

  modport source (
    output valid, opcode, axis_sel, delta_deg, last_axis, now_ms,
    input  ready
  );

  modport sink (
    input  valid, opcode, axis_sel, delta_deg, last_axis, now_ms,
    output ready
  );
endinterface

`default_nettype wire

### hdl/smi_out_if.sv
`default_nettype none

interface smi_out_if;
  logic                               valid;
  logic                               ready;
  logic [smi_pkg::AXIS_FIELD_W-1:0]   axis_out;
  logic signed [smi_pkg::ANGLE_W-1:0] angle_deg;
  logic                               in_motion;
  logic                               last_out;

  modport source (
    output valid, axis_out, angle_deg, in_motion, last_out,
    input  ready
  );

  modport sink (
    input  valid, axis_out, angle_deg, in_motion, last_out,
    output ready
  );
endinterface

`default_nettype wire

### hdl/smi_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The remainder may be
// preloaded with a value below the divisor, which lets a fraction be formed
// by shifting in zeros only.
module smi_div (
  input  logic              clk,
  input  logic              rst_n,
  input  smi_pkg::div_req_t req,
  output smi_pkg::div_rsp_t rsp
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [smi_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [smi_pkg::DEN_W-1:0]    rem_r, rem_nxt;
  logic [smi_pkg::DEN_W-1:0]    den_r, den_nxt;
  logic [smi_pkg::NUM_W-1:0]    num_r, num_nxt;

  logic [smi_pkg::DEN_W:0]      shifted;
  logic [smi_pkg::DEN_W+1:0]    trial;
  logic                         qbit;

  assign shifted = {rem_r, num_r[smi_pkg::NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};
  assign qbit    = ~trial[smi_pkg::DEN_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = req.rem_init;
      den_nxt  = req.denom;
      num_nxt  = req.numer;
    end else if (busy_r) begin
      rem_nxt = qbit ? trial[smi_pkg::DEN_W-1:0] : shifted[smi_pkg::DEN_W-1:0];
      num_nxt = {num_r[smi_pkg::NUM_W-2:0], qbit};
      cnt_nxt = cnt_r - smi_pkg::STEP_W'(1);
      if (cnt_r == smi_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = num_r;

`ifndef NO_ASSERTIONS
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with an exhausted step count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider flags done while still iterating");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r)
    else $error("divider did not begin after a start request");
`endif

endmodule

`default_nettype wire

### hdl/smi_mul.sv
`default_nettype none

// Shared multiplier: signed A by unsigned B, product registered.
module smi_mul (
  input  logic                                clk,
  input  logic signed [smi_pkg::MUL_A_W-1:0]  a,
  input  logic [smi_pkg::MUL_B_W-1:0]         b,
  output logic signed [smi_pkg::MUL_P_W-1:0]  p
);

  logic signed [smi_pkg::MUL_P_W-1:0] p_r;
  logic signed [smi_pkg::MUL_P_W-1:0] p_nxt;

  assign p_nxt = smi_pkg::MUL_P_W'(a * $signed({1'b0, b}));

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

`default_nettype wire

### hdl/multi_axis_smoothstep_interpolator_top.sv
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   opcode, axis_sel, delta_deg, last_axis, now_ms
// out_ch    out  valid/ready   axis_out, angle_deg, in_motion, last_out
// cfg       in   cfg_we        cfg_idx, cfg_wdata (rated_rpm, min/max_move_ms)
//
// A load passes through S_LOAD; the load that closes a command then multiplies
// the largest delta by 1000 and runs the 41 steps of the shared restoring
// divider that forms the duration. A tick emits all axes directly when idle or
// when the move expires; while moving it first runs 16 divider steps for the
// phase, two shared multiplies for the easing curve and a multiply and an add
// per axis. A stalled output holds the sequencer in its emit phase. Reset is
// synchronous; it clears the control state and angles and loads the config defaults.
`default_nettype none

module multi_axis_smoothstep_interpolator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  smi_in_if.sink                            in_ch,
  smi_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [smi_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [smi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int Q_W      = smi_pkg::MUL_P_W - smi_pkg::FRAC_W;
  localparam int SUM_W    = Q_W + 1;
  localparam int AX_CMP_W = smi_pkg::AXIS_FIELD_W + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DUR_MUL,
    S_DUR_GO,
    S_DUR_DIV,
    S_TICK,
    S_T_DIV,
    S_T_SQ,
    S_T_CUBE,
    S_T_S,
    S_AX_MUL,
    S_AX_ADD,
    S_EMIT
  } state_t;

  typedef logic signed [smi_pkg::ANGLE_W-1:0] angle_t;

  state_t                             state_r, state_nxt;
  logic [smi_pkg::AXIS_IDX_W-1:0]     ax_r, ax_nxt;

  logic [smi_pkg::AXIS_FIELD_W-1:0]   in_axis_r, in_axis_nxt;
  angle_t                             in_delta_r, in_delta_nxt;
  logic                               in_last_r, in_last_nxt;
  logic [smi_pkg::TIME_W-1:0]         in_now_r, in_now_nxt;

  logic [smi_pkg::RPM_W-1:0]          rpm_r, rpm_nxt;
  logic [smi_pkg::DUR_W-1:0]          min_ms_r, min_ms_nxt;
  logic [smi_pkg::DUR_W-1:0]          max_ms_r, max_ms_nxt;

  angle_t                             cur_r    [smi_pkg::AXIS_COUNT];
  angle_t                             cur_nxt  [smi_pkg::AXIS_COUNT];
  angle_t                             start_r  [smi_pkg::AXIS_COUNT];
  angle_t                             start_nxt[smi_pkg::AXIS_COUNT];
  angle_t                             tgt_r    [smi_pkg::AXIS_COUNT];
  angle_t                             tgt_nxt  [smi_pkg::AXIS_COUNT];

  logic [smi_pkg::TIME_W-1:0]         start_time_r, start_time_nxt;
  logic [smi_pkg::DUR_W-1:0]          dur_r, dur_nxt;
  logic [smi_pkg::MAG_W-1:0]          largest_r, largest_nxt;
  logic                               armed_r, armed_nxt;
  logic                               moving_r, moving_nxt;
  logic [smi_pkg::FRAC_W-1:0]         t_r, t_nxt;
  logic [smi_pkg::SMOOTH_W-1:0]       s_r, s_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [smi_pkg::AXIS_FIELD_W-1:0]   out_axis_r, out_axis_nxt;
  angle_t                             out_angle_r, out_angle_nxt;
  logic                               out_motion_r, out_motion_nxt;
  logic                               out_last_r, out_last_nxt;

  // Datapath
  logic [smi_pkg::AXIS_IDX_W-1:0]     ld_idx, rd_idx;
  logic                               ld_ok;
  angle_t                             cur_rd, st_rd, tg_rd;
  logic [smi_pkg::ANGLE_W:0]          ld_sum;
  angle_t                             ld_sat;
  logic [smi_pkg::MAG_W-1:0]          mag;
  logic [smi_pkg::ANGLE_W:0]          diff;
  logic [smi_pkg::TIME_W-1:0]         eff_start, elapsed;
  logic                               expired;
  logic                               moving_eff;
  logic                               ax_last;
  logic [Q_W-1:0]                     q_floor, q_trunc;
  logic [SUM_W-1:0]                   ax_sum;
  angle_t                             ax_sat;
  logic [smi_pkg::DEN_W-1:0]          rpm_den;
  logic [smi_pkg::RPM_W-1:0]          rpm_eff;
  logic [smi_pkg::NUM_W-1:0]          min_ext, max_ext, raised, clamped;
  logic                               out_free;

  logic signed [smi_pkg::MUL_A_W-1:0] mul_a;
  logic [smi_pkg::MUL_B_W-1:0]        mul_b;
  logic signed [smi_pkg::MUL_P_W-1:0] p_r;

  smi_pkg::div_req_t                  div_req;
  smi_pkg::div_rsp_t                  div_rsp;

  smi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  smi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p_r)
  );

  assign ld_idx = in_axis_r[smi_pkg::AXIS_IDX_W-1:0];
  assign ld_ok  = ({1'b0, in_axis_r} < AX_CMP_W'(smi_pkg::AXIS_COUNT));
  assign rd_idx = (state_r == S_LOAD) ? ld_idx : ax_r;
  assign cur_rd = cur_r[rd_idx];
  assign st_rd  = start_r[ax_r];
  assign tg_rd  = tgt_r[ax_r];

  assign ld_sum = {cur_rd[smi_pkg::ANGLE_W-1], cur_rd}
                + {in_delta_r[smi_pkg::ANGLE_W-1], in_delta_r};
  assign ld_sat = (ld_sum[smi_pkg::ANGLE_W] == ld_sum[smi_pkg::ANGLE_W-1])
                ? ld_sum[smi_pkg::ANGLE_W-1:0]
                : (ld_sum[smi_pkg::ANGLE_W] ? smi_pkg::ANGLE_MIN : smi_pkg::ANGLE_MAX);

  // The most negative delta negates to 2^31, which is its exact magnitude.
  assign mag = in_delta_r[smi_pkg::ANGLE_W-1] ? (~in_delta_r + smi_pkg::MAG_W'(1))
                                              : in_delta_r;

  assign diff = {tg_rd[smi_pkg::ANGLE_W-1], tg_rd} - {st_rd[smi_pkg::ANGLE_W-1], st_rd};

  assign moving_eff = armed_r | moving_r;
  assign eff_start  = armed_r ? in_now_r : start_time_r;
  assign elapsed    = in_now_r - eff_start;
  assign expired    = (elapsed >= smi_pkg::TIME_W'(dur_r));

  // Arithmetic shift floors; add one back for inexact negative products so
  // that the quotient rounds toward zero.
  assign q_floor = p_r[smi_pkg::MUL_P_W-1:smi_pkg::FRAC_W];
  assign q_trunc = (p_r[smi_pkg::MUL_P_W-1] && (|p_r[smi_pkg::FRAC_W-1:0]))
                 ? q_floor + Q_W'(1) : q_floor;
  assign ax_sum  = {{(SUM_W-smi_pkg::ANGLE_W){st_rd[smi_pkg::ANGLE_W-1]}}, st_rd}
                 + {q_trunc[Q_W-1], q_trunc};
  assign ax_sat  = ((&ax_sum[SUM_W-1:smi_pkg::ANGLE_W-1]) ||
                    !(|ax_sum[SUM_W-1:smi_pkg::ANGLE_W-1]))
                 ? ax_sum[smi_pkg::ANGLE_W-1:0]
                 : (ax_sum[SUM_W-1] ? smi_pkg::ANGLE_MIN : smi_pkg::ANGLE_MAX);

  assign ax_last = (ax_r == smi_pkg::AXIS_IDX_W'(smi_pkg::AXIS_COUNT - 1));

  // 1536 * rpm as two shifted copies.
  assign rpm_eff = (rpm_r == '0) ? smi_pkg::RPM_W'(1) : rpm_r;
  assign rpm_den = smi_pkg::DEN_W'({rpm_eff, 10'b0}) + smi_pkg::DEN_W'({rpm_eff, 9'b0});

  // Raise to the minimum first, then lower to the maximum.
  assign min_ext = smi_pkg::NUM_W'(min_ms_r);
  assign max_ext = smi_pkg::NUM_W'(max_ms_r);
  assign raised  = (div_rsp.quot < min_ext) ? min_ext : div_rsp.quot;
  assign clamped = (raised > max_ext) ? max_ext : raised;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DUR_MUL: begin
        mul_a = $signed(smi_pkg::MUL_A_W'(largest_r));
        mul_b = smi_pkg::MS_PER_S;
      end
      S_T_SQ: begin
        mul_a = $signed(smi_pkg::MUL_A_W'(t_r));
        mul_b = smi_pkg::MUL_B_W'(t_r);
      end
      S_T_CUBE: begin
        mul_a = $signed(smi_pkg::MUL_A_W'(p_r[2*smi_pkg::FRAC_W-1:smi_pkg::FRAC_W]));
        mul_b = smi_pkg::SMOOTH_THREE - {1'b0, t_r, 1'b0};
      end
      S_AX_MUL: begin
        mul_a = $signed({diff[smi_pkg::ANGLE_W], diff});
        mul_b = smi_pkg::MUL_B_W'(s_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.numer    = '0;
    div_req.rem_init = smi_pkg::DEN_W'(elapsed[smi_pkg::DUR_W-1:0]);
    div_req.denom    = smi_pkg::DEN_W'(dur_r);
    div_req.steps    = smi_pkg::STEPS_PHASE;
    if (state_r == S_DUR_GO) begin
      div_req.start    = 1'b1;
      div_req.numer    = p_r[smi_pkg::NUM_W-1:0];
      div_req.rem_init = '0;
      div_req.denom    = rpm_den;
      div_req.steps    = smi_pkg::STEPS_DURATION;
    end else if (state_r == S_TICK) begin
      div_req.start = moving_eff && !expired;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ax_nxt         = ax_r;
    in_axis_nxt    = in_axis_r;
    in_delta_nxt   = in_delta_r;
    in_last_nxt    = in_last_r;
    in_now_nxt     = in_now_r;
    rpm_nxt        = rpm_r;
    min_ms_nxt     = min_ms_r;
    max_ms_nxt     = max_ms_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    tgt_nxt        = tgt_r;
    start_time_nxt = start_time_r;
    dur_nxt        = dur_r;
    largest_nxt    = largest_r;
    armed_nxt      = armed_r;
    moving_nxt     = moving_r;
    t_nxt          = t_r;
    s_nxt          = s_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_axis_nxt   = out_axis_r;
    out_angle_nxt  = out_angle_r;
    out_motion_nxt = out_motion_r;
    out_last_nxt   = out_last_r;

    if (cfg_we) begin
      case (smi_pkg::cfg_reg_t'(cfg_idx))
        smi_pkg::CFG_RATED_RPM:   rpm_nxt    = cfg_wdata[smi_pkg::RPM_W-1:0];
        smi_pkg::CFG_MIN_MOVE_MS: min_ms_nxt = cfg_wdata[smi_pkg::DUR_W-1:0];
        smi_pkg::CFG_MAX_MOVE_MS: max_ms_nxt = cfg_wdata[smi_pkg::DUR_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          in_axis_nxt  = in_ch.axis_sel;
          in_delta_nxt = in_ch.delta_deg;
          in_last_nxt  = in_ch.last_axis;
          in_now_nxt   = in_ch.now_ms;
          state_nxt    = (in_ch.opcode == smi_pkg::OP_TICK) ? S_TICK : S_LOAD;
        end
      end
      S_LOAD: begin
        if (ld_ok) begin
          start_nxt[ld_idx] = cur_rd;
          tgt_nxt[ld_idx]   = ld_sat;
          if (mag > largest_r) begin
            largest_nxt = mag;
          end
        end
        moving_nxt = 1'b0;
        state_nxt  = in_last_r ? S_DUR_MUL : S_IDLE;
      end
      S_DUR_MUL: begin
        state_nxt = S_DUR_GO;
      end
      S_DUR_GO: begin
        state_nxt = S_DUR_DIV;
      end
      S_DUR_DIV: begin
        if (div_rsp.done) begin
          dur_nxt     = clamped[smi_pkg::DUR_W-1:0];
          armed_nxt   = 1'b1;
          largest_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end
      S_TICK: begin
        ax_nxt = '0;
        if (armed_r) begin
          start_time_nxt = in_now_r;
          armed_nxt      = 1'b0;
          moving_nxt     = 1'b1;
        end
        if (moving_eff) begin
          if (expired) begin
            for (int i = 0; i < smi_pkg::AXIS_COUNT; i++) begin
              cur_nxt[i] = tgt_r[i];
            end
            moving_nxt = 1'b0;
            state_nxt  = S_EMIT;
          end else begin
            state_nxt = S_T_DIV;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_T_DIV: begin
        if (div_rsp.done) begin
          t_nxt     = div_rsp.quot[smi_pkg::FRAC_W-1:0];
          state_nxt = S_T_SQ;
        end
      end
      S_T_SQ: begin
        state_nxt = S_T_CUBE;
      end
      S_T_CUBE: begin
        state_nxt = S_T_S;
      end
      S_T_S: begin
        s_nxt     = p_r[smi_pkg::FRAC_W+smi_pkg::SMOOTH_W-1:smi_pkg::FRAC_W];
        ax_nxt    = '0;
        state_nxt = S_AX_MUL;
      end
      S_AX_MUL: begin
        state_nxt = S_AX_ADD;
      end
      S_AX_ADD: begin
        cur_nxt[ax_r] = ax_sat;
        if (ax_last) begin
          ax_nxt    = '0;
          state_nxt = S_EMIT;
        end else begin
          ax_nxt    = ax_r + smi_pkg::AXIS_IDX_W'(1);
          state_nxt = S_AX_MUL;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_axis_nxt   = smi_pkg::AXIS_FIELD_W'(ax_r);
          out_angle_nxt  = cur_rd;
          out_motion_nxt = moving_r;
          out_last_nxt   = ax_last;
          if (ax_last) begin
            ax_nxt    = '0;
            state_nxt = S_IDLE;
          end else begin
            ax_nxt = ax_r + smi_pkg::AXIS_IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ax_r         <= '0;
      rpm_r        <= smi_pkg::RPM_RESET;
      min_ms_r     <= smi_pkg::MIN_MS_RESET;
      max_ms_r     <= smi_pkg::MAX_MS_RESET;
      for (int i = 0; i < smi_pkg::AXIS_COUNT; i++) begin
        cur_r[i]   <= '0;
        start_r[i] <= '0;
        tgt_r[i]   <= '0;
      end
      start_time_r <= '0;
      dur_r        <= '0;
      largest_r    <= '0;
      armed_r      <= 1'b0;
      moving_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ax_r         <= ax_nxt;
      rpm_r        <= rpm_nxt;
      min_ms_r     <= min_ms_nxt;
      max_ms_r     <= max_ms_nxt;
      cur_r        <= cur_nxt;
      start_r      <= start_nxt;
      tgt_r        <= tgt_nxt;
      start_time_r <= start_time_nxt;
      dur_r        <= dur_nxt;
      largest_r    <= largest_nxt;
      armed_r      <= armed_nxt;
      moving_r     <= moving_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    in_axis_r    <= in_axis_nxt;
    in_delta_r   <= in_delta_nxt;
    in_last_r    <= in_last_nxt;
    in_now_r     <= in_now_nxt;
    t_r          <= t_nxt;
    s_r          <= s_nxt;
    out_axis_r   <= out_axis_nxt;
    out_angle_r  <= out_angle_nxt;
    out_motion_r <= out_motion_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.axis_out  = out_axis_r;
  assign out_ch.angle_deg = out_angle_r;
  assign out_ch.in_motion = out_motion_r;
  assign out_ch.last_out  = out_last_r;

`ifndef NO_ASSERTIONS
  a_armed_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
    !(armed_r && moving_r))
    else $error("a move is armed and running at the same time");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_DIV || state_r == S_DUR_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("sequencer waits on a divider that is not working");

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) == S_EMIT) |-> (out_valid_r && out_last_r))
    else $error("tick finished without presenting the final axis");
`endif

endmodule

`default_nettype wire

### tb/multi_axis_smoothstep_interpolator_top_tb.sv
`timescale 1ns / 1ps

module multi_axis_smoothstep_interpolator_top_tb;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int SETTLE_CYCLES    = 100;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int PHASE_COUNT      = 7;

  // Index 3 has no register behind it, so a write there must change nothing.
  localparam logic [smi_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [smi_pkg::TIME_W-1:0]    WRAP_T0       = 32'hFFFF_FF00;

  typedef struct packed {
    smi_pkg::opcode_t                   op;
    logic [smi_pkg::AXIS_FIELD_W-1:0]   axis;
    logic signed [smi_pkg::ANGLE_W-1:0] delta;
    logic                               last;
    logic [smi_pkg::TIME_W-1:0]         now;
  } motion_cmd_t;

  typedef struct packed {
    logic [smi_pkg::AXIS_FIELD_W-1:0]   axis;
    logic signed [smi_pkg::ANGLE_W-1:0] angle;
    logic                               moving;
    logic                               last;
  } axis_report_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [smi_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [smi_pkg::CFG_DATA_W-1:0] cfg_wdata;

  smi_in_if  in_ch ();
  smi_out_if out_ch ();

  multi_axis_smoothstep_interpolator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  motion_cmd_t  motion_cmds[$];
  axis_report_t angle_reports[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int          mismatch_count;
  int          cycle_count;
  bit          in_taken;
  logic [smi_pkg::TIME_W-1:0] gen_clock;

  // Predicted state of the interpolator.
  logic [smi_pkg::RPM_W-1:0]          rpm_reg;
  logic [smi_pkg::DUR_W-1:0]          min_ms_reg;
  logic [smi_pkg::DUR_W-1:0]          max_ms_reg;
  logic signed [smi_pkg::ANGLE_W-1:0] cur_ang [smi_pkg::AXIS_COUNT];
  logic signed [smi_pkg::ANGLE_W-1:0] from_ang [smi_pkg::AXIS_COUNT];
  logic signed [smi_pkg::ANGLE_W-1:0] to_ang [smi_pkg::AXIS_COUNT];
  logic [smi_pkg::TIME_W-1:0]         t0_ms;
  logic [smi_pkg::DUR_W-1:0]          dur_ms;
  longint                             peak_mag;
  bit                                 armed;
  bit                                 moving;

  function automatic logic signed [smi_pkg::ANGLE_W-1:0] clip_angle(longint v);
    if (v > longint'(smi_pkg::ANGLE_MAX)) return smi_pkg::ANGLE_MAX;
    if (v < longint'(smi_pkg::ANGLE_MIN)) return smi_pkg::ANGLE_MIN;
    return v[smi_pkg::ANGLE_W-1:0];
  endfunction

  // Duration of a move whose largest rotation is mag, under the current settings.
  function automatic logic [smi_pkg::DUR_W-1:0] move_time_ms(longint mag);
    longint rpm;
    longint ms;
    rpm = (rpm_reg == 0) ? 1 : longint'(rpm_reg);
    ms = (mag * 1000) / (1536 * rpm);
    if (ms < longint'(min_ms_reg)) ms = longint'(min_ms_reg);
    if (ms > longint'(max_ms_reg)) ms = longint'(max_ms_reg);
    return ms[smi_pkg::DUR_W-1:0];
  endfunction

  task automatic advance_axes(motion_cmd_t c);
    longint d;
    longint mag;
    longint unsigned el;
    longint t;
    longint t2;
    longint s;
    longint diff;
    longint q;
    logic [smi_pkg::TIME_W-1:0] elapsed;
    axis_report_t r;
    if (c.op == smi_pkg::OP_LOAD) begin
      if (c.axis < smi_pkg::AXIS_COUNT) begin
        d = longint'(c.delta);
        mag = (d < 0) ? -d : d;
        from_ang[c.axis] = cur_ang[c.axis];
        to_ang[c.axis] = clip_angle(longint'(cur_ang[c.axis]) + d);
        if (mag > peak_mag) peak_mag = mag;
      end
      moving = 1'b0;
      if (c.last) begin
        dur_ms = move_time_ms(peak_mag);
        armed = 1'b1;
        peak_mag = 0;
      end
    end else begin
      if (armed) begin
        t0_ms = c.now;
        armed = 1'b0;
        moving = 1'b1;
      end
      if (moving) begin
        elapsed = c.now - t0_ms;
        if (elapsed >= dur_ms) begin
          for (int i = 0; i < smi_pkg::AXIS_COUNT; i++) cur_ang[i] = to_ang[i];
          moving = 1'b0;
        end else begin
          el = elapsed;
          t = longint'((el << 16) / dur_ms);
          t2 = (t * t) >>> 16;
          s = (t2 * (3 * 65536 - 2 * t)) >>> 16;
          for (int i = 0; i < smi_pkg::AXIS_COUNT; i++) begin
            diff = longint'(to_ang[i]) - longint'(from_ang[i]);
            q = (diff * s) / 65536;
            cur_ang[i] = clip_angle(longint'(from_ang[i]) + q);
          end
        end
      end
      for (int i = 0; i < smi_pkg::AXIS_COUNT; i++) begin
        r.axis = i[smi_pkg::AXIS_FIELD_W-1:0];
        r.angle = cur_ang[i];
        r.moving = moving;
        r.last = (i == smi_pkg::AXIS_COUNT - 1);
        angle_reports.push_back(r);
      end
    end
  endtask

  function automatic motion_cmd_t load_cmd(logic [smi_pkg::AXIS_FIELD_W-1:0] ax,
                                           logic signed [smi_pkg::ANGLE_W-1:0] d,
                                           logic fin);
    motion_cmd_t c;
    c.op = smi_pkg::OP_LOAD;
    c.axis = ax;
    c.delta = d;
    c.last = fin;
    c.now = $urandom;
    return c;
  endfunction

  function automatic motion_cmd_t tick_cmd(logic [smi_pkg::TIME_W-1:0] now);
    motion_cmd_t c;
    c.op = smi_pkg::OP_TICK;
    c.axis = smi_pkg::AXIS_FIELD_W'($urandom_range(0, 15));
    c.delta = $urandom;
    c.last = $urandom_range(0, 1);
    c.now = now;
    return c;
  endfunction

  function automatic logic signed [smi_pkg::ANGLE_W-1:0] pick_delta();
    int span;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return smi_pkg::ANGLE_MAX;
          1: return smi_pkg::ANGLE_MIN;
          2: return 0;
          default: return -1;
        endcase
      end
      default: begin
        span = 1 << $urandom_range(8, 24);
        return int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
  endfunction

  // Mostly complete commands followed by a run of ticks across the move,
  // with stray loads, random ticks and broken commands mixed in.
  task automatic queue_random(int count);
    int made;
    int k;
    int ticks;
    logic [smi_pkg::AXIS_FIELD_W-1:0] ax;
    logic signed [smi_pkg::ANGLE_W-1:0] d;
    longint mag;
    longint peak_est;
    logic [smi_pkg::DUR_W-1:0] est;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 75) begin
        k = $urandom_range(1, smi_pkg::AXIS_COUNT);
        peak_est = 0;
        for (int j = 0; j < k; j++) begin
          ax = ($urandom_range(0, 19) == 0)
             ? smi_pkg::AXIS_FIELD_W'($urandom_range(smi_pkg::AXIS_COUNT, 15))
             : smi_pkg::AXIS_FIELD_W'($urandom_range(0, smi_pkg::AXIS_COUNT - 1));
          d = pick_delta();
          mag = (d < 0) ? -longint'(d) : longint'(d);
          if (ax < smi_pkg::AXIS_COUNT && mag > peak_est) peak_est = mag;
          motion_cmds.push_back(load_cmd(ax, d, j == k - 1));
        end
        made += k;
        est = move_time_ms(peak_est);
        if ($urandom_range(0, 9) == 0) gen_clock = 32'hFFFF_FFFF - $urandom_range(0, est);
        ticks = $urandom_range(1, 8);
        for (int j = 0; j < ticks; j++) begin
          gen_clock += (j == 0) ? $urandom_range(0, 50) : $urandom_range(0, est / 3 + 1);
          motion_cmds.push_back(tick_cmd(gen_clock));
          made++;
          if ($urandom_range(0, 19) == 0) begin
            motion_cmds.push_back(load_cmd(smi_pkg::AXIS_FIELD_W'($urandom), pick_delta(),
                                           1'b0));
            made++;
          end
        end
      end else begin
        if ($urandom_range(0, 1) == 1)
          motion_cmds.push_back(tick_cmd($urandom));
        else
          motion_cmds.push_back(load_cmd(smi_pkg::AXIS_FIELD_W'($urandom), $urandom,
                                         $urandom_range(0, 3) == 0));
        made++;
      end
    end
  endtask

  task automatic write_reg(logic [smi_pkg::CFG_IDX_W-1:0] idx,
                           logic [smi_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      smi_pkg::CFG_RATED_RPM:   rpm_reg = val[smi_pkg::RPM_W-1:0];
      smi_pkg::CFG_MIN_MOVE_MS: min_ms_reg = val[smi_pkg::DUR_W-1:0];
      smi_pkg::CFG_MAX_MOVE_MS: max_ms_reg = val[smi_pkg::DUR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads produce no transfer, so the block gets extra cycles after the last one.
  task automatic wait_quiet();
    while (motion_cmds.size() != 0 || in_ch.valid) @(posedge clk);
    while (angle_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin : feed
    motion_cmd_t nxt;
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (motion_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt = motion_cmds.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= nxt.op;
          in_ch.axis_sel <= nxt.axis;
          in_ch.delta_deg <= nxt.delta;
          in_ch.last_axis <= nxt.last;
          in_ch.now_ms <= nxt.now;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    motion_cmd_t took;
    axis_report_t seen;
    axis_report_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_n) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (in_taken) begin
        took.op = smi_pkg::opcode_t'(in_ch.opcode);
        took.axis = in_ch.axis_sel;
        took.delta = in_ch.delta_deg;
        took.last = in_ch.last_axis;
        took.now = in_ch.now_ms;
        advance_axes(took);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen = {out_ch.axis_out, out_ch.angle_deg, out_ch.in_motion, out_ch.last_out};
        if (angle_reports.size() == 0) begin
          $display("%0t: unexpected transfer: axis %0d angle %0d motion %0b last %0b",
                   $time, seen.axis, seen.angle, seen.moving, seen.last);
          mismatch_count++;
        end else begin
          want = angle_reports.pop_front();
          if (seen !== want) begin
            $display("%0t: expected axis %0d angle %0d motion %0b last %0b",
                     $time, want.axis, want.angle, want.moving, want.last);
            $display("%0t: actual   axis %0d angle %0d motion %0b last %0b",
                     $time, seen.axis, seen.angle, seen.moving, seen.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = smi_pkg::OP_LOAD;
    in_ch.axis_sel = '0;
    in_ch.delta_deg = '0;
    in_ch.last_axis = 1'b0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    gen_clock = '0;
    rpm_reg = smi_pkg::RPM_RESET;
    min_ms_reg = smi_pkg::MIN_MS_RESET;
    max_ms_reg = smi_pkg::MAX_MS_RESET;
    for (int i = 0; i < smi_pkg::AXIS_COUNT; i++) begin
      cur_ang[i] = '0;
      from_ang[i] = '0;
      to_ang[i] = '0;
    end
    t0_ms = '0;
    dur_ms = '0;
    peak_mag = 0;
    armed = 1'b0;
    moving = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Idle tick, then a command with both extreme deltas and an axis out of
    // range, ticked across a time wrap up to and past expiry.
    motion_cmds.push_back(tick_cmd(32'd0));
    motion_cmds.push_back(load_cmd(4'd0, smi_pkg::ANGLE_MAX, 1'b0));
    motion_cmds.push_back(load_cmd(4'd11, smi_pkg::ANGLE_MIN, 1'b0));
    motion_cmds.push_back(load_cmd(4'd15, 32'sh1234_5678, 1'b0));
    motion_cmds.push_back(load_cmd(4'd5, 32'sh0000_5A00, 1'b1));
    motion_cmds.push_back(tick_cmd(WRAP_T0));
    motion_cmds.push_back(tick_cmd(WRAP_T0 + 32'd1000));
    motion_cmds.push_back(tick_cmd(WRAP_T0 + 32'd3000));
    motion_cmds.push_back(tick_cmd(WRAP_T0 + 32'd3999));
    motion_cmds.push_back(tick_cmd(WRAP_T0 + 32'd4000));
    motion_cmds.push_back(tick_cmd(WRAP_T0 + 32'd4001));
    // Targets saturate from angles already at the limits.
    motion_cmds.push_back(load_cmd(4'd0, smi_pkg::ANGLE_MAX, 1'b0));
    motion_cmds.push_back(load_cmd(4'd11, smi_pkg::ANGLE_MIN, 1'b1));
    motion_cmds.push_back(tick_cmd(32'd5));
    motion_cmds.push_back(tick_cmd(32'd2005));
    // A load in the middle of a move stops it.
    motion_cmds.push_back(load_cmd(4'd2, 32'sh0000_0400, 1'b0));
    motion_cmds.push_back(tick_cmd(32'd2100));
    wait_quiet();

    // Zero duration: an armed move lands on its first tick.
    write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd0);
    write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'd0);
    motion_cmds.push_back(load_cmd(4'd3, 32'sh0000_0100, 1'b1));
    motion_cmds.push_back(tick_cmd(32'd7));
    motion_cmds.push_back(load_cmd(4'd12, smi_pkg::ANGLE_MAX, 1'b1));
    motion_cmds.push_back(tick_cmd(32'd9));
    motion_cmds.push_back(load_cmd(4'd2, -32'sd512, 1'b1));
    motion_cmds.push_back(tick_cmd(32'hFFFF_FFFF));
    wait_quiet();

    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd60);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd800);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'd4000);
        end
        1: begin
          write_reg(CFG_SPARE_IDX, 16'hFFFF);
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd600);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd0);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'hFFFF);
        end
        2: begin
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd1);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd100);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'd300);
        end
        3: begin
          // A zero speed counts as one, and the upper clamp wins over the lower.
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd0);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd5000);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'd2000);
        end
        4: begin
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd1023);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd0);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'd0);
        end
        5: begin
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd300);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'hFFFF);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'hFFFF);
        end
        default: begin
          write_reg(smi_pkg::CFG_RATED_RPM, 16'd45);
          write_reg(smi_pkg::CFG_MIN_MOVE_MS, 16'd0);
          write_reg(smi_pkg::CFG_MAX_MOVE_MS, 16'd1500);
        end
      endcase
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 82;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 82;
        end
        default: begin
          sender_idle_pct = 12;
          receiver_stall_pct = 12;
        end
      endcase
      queue_random(RANDOM_PER_PHASE);
      wait_quiet();
    end

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
hdl/smi_pkg.sv
hdl/smi_in_if.sv
hdl/smi_out_if.sv
hdl/smi_div.sv
hdl/smi_mul.sv
hdl/multi_axis_smoothstep_interpolator_top.sv
tb/multi_axis_smoothstep_interpolator_top_tb.sv
